>>> hdl/key_debounce_event_fifo_assert.svh
// Assertion macros shared by the key debounce event FIFO modules.
`ifndef KEY_DEBOUNCE_EVENT_FIFO_ASSERT_SVH
`define KEY_DEBOUNCE_EVENT_FIFO_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KDEF_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key_debounce_event_fifo: assertion failed");

// Next-cycle implication, checked outside reset.
`define KDEF_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key_debounce_event_fifo: assertion failed");

`endif

>>> hdl/kdef_pkg.sv
// Shared types, constants and helpers of the key debounce event FIFO.
`timescale 1ns / 1ps
package kdef_pkg;

  localparam int KDEF_NUM_KEYS    = 4;
  localparam int KDEF_QUEUE_DEPTH = 16;

  localparam int KDEF_LEVELS_W    = 4;
  localparam int KDEF_CODE_W      = 4;
  localparam int KDEF_FT_W        = 6;
  localparam int KDEF_CNT_W       = KDEF_FT_W + 1;
  localparam int KDEF_TICK_W      = 16;
  localparam int KDEF_KIDX_MAX_W  = 3;
  localparam int KDEF_CFG_IDX_W   = 2;
  localparam int KDEF_CFG_DATA_W  = 16;

  localparam logic [KDEF_FT_W-1:0]   KDEF_FILTER_RESET = KDEF_FT_W'(5);
  localparam logic [KDEF_TICK_W-1:0] KDEF_LONG_RESET   = KDEF_TICK_W'(100);
  localparam logic [KDEF_TICK_W-1:0] KDEF_REPEAT_RESET = '0;
  localparam logic [KDEF_CNT_W-1:0]  KDEF_COUNT_RESET  = KDEF_CNT_W'(5 / 2);

  typedef enum logic [1:0] {
    CMD_SCAN  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } kdef_cmd_e;

  typedef enum logic [KDEF_CFG_IDX_W-1:0] {
    REG_FILTER = 2'd0,
    REG_LONG   = 2'd1,
    REG_REPEAT = 2'd2
  } kdef_reg_e;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_LONG    = 2'd3
  } kdef_kind_e;

  typedef struct packed {
    logic [1:0]               command;
    logic [KDEF_LEVELS_W-1:0] key_levels;
  } kdef_in_t;

  typedef struct packed {
    logic [KDEF_CODE_W-1:0] key_code;
    logic                   queue_empty;
    logic                   overflowed;
  } kdef_out_t;

  typedef struct packed {
    logic [KDEF_FT_W-1:0]   filter_time;
    logic [KDEF_TICK_W-1:0] long_time;
    logic [KDEF_TICK_W-1:0] repeat_period;
  } kdef_cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic start;
    logic key_step;
    logic push_long;
    logic pop;
    logic clear;
  } kdef_cmd_t;

  // Event code 3k + kind, kept to the stored code width.
  function automatic logic [KDEF_CODE_W-1:0] kdef_code(
    input logic [KDEF_KIDX_MAX_W-1:0] k,
    input kdef_kind_e                 kind
  );
    logic [KDEF_KIDX_MAX_W+1:0] sum;
    sum = {1'b0, k, 1'b0} + {2'b00, k} + {{KDEF_KIDX_MAX_W{1'b0}}, kind};
    return sum[KDEF_CODE_W-1:0];
  endfunction

endpackage

>>> hdl/kdef_keys.sv
// Per-key debounce, long-press and repeat datapath, one key per step.
`timescale 1ns / 1ps
module kdef_keys import kdef_pkg::*; #(
  parameter int NUM_KEYS = KDEF_NUM_KEYS,
  localparam int KIDX_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kdef_cfg_t                cfg_i,
  input  kdef_cmd_t                cmd_i,
  input  logic [KIDX_W-1:0]        key_idx_i,
  input  logic [KDEF_LEVELS_W-1:0] levels_i,
  output logic                     long_pend_o,
  output logic                     ev_valid_o,
  output logic [KDEF_CODE_W-1:0]   ev_code_o
);

  logic [KDEF_LEVELS_W-1:0] levels_q;
  logic [NUM_KEYS-1:0]      level_vec;

  logic [KDEF_CNT_W-1:0]  cnt_q     [NUM_KEYS];
  logic                   pressed_q [NUM_KEYS];
  logic [KDEF_TICK_W-1:0] hold_q    [NUM_KEYS];
  logic [KDEF_TICK_W-1:0] rep_q     [NUM_KEYS];

  logic                   down;
  logic [KDEF_CNT_W-1:0]  cnt, cnt_d, ft_ext, band;
  logic                   pressed, pressed_d;
  logic [KDEF_TICK_W-1:0] hold, hold_d, hold_inc;
  logic [KDEF_TICK_W-1:0] rep, rep_d, rep_inc;
  logic                   ev_press, ev_rel, ev_rep, ev_long;
  logic [KDEF_KIDX_MAX_W-1:0] k_ext;
  logic [KDEF_CODE_W-1:0] code_a;
  logic                   a_valid;

  // keys past the level field always read released
  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lvl
    if (i < KDEF_LEVELS_W) begin : g_on
      assign level_vec[i] = levels_q[i];
    end else begin : g_off
      assign level_vec[i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      levels_q <= levels_i;
    end
  end

  assign down     = level_vec[key_idx_i];
  assign cnt      = cnt_q[key_idx_i];
  assign pressed  = pressed_q[key_idx_i];
  assign hold     = hold_q[key_idx_i];
  assign rep      = rep_q[key_idx_i];
  assign ft_ext   = {1'b0, cfg_i.filter_time};
  assign band     = {cfg_i.filter_time, 1'b0};
  assign hold_inc = hold + KDEF_TICK_W'(1);
  assign rep_inc  = rep + KDEF_TICK_W'(1);
  assign k_ext    = KDEF_KIDX_MAX_W'(key_idx_i);

  always_comb begin
    cnt_d     = cnt;
    pressed_d = pressed;
    hold_d    = hold;
    rep_d     = rep;
    ev_press  = 1'b0;
    ev_rel    = 1'b0;
    ev_rep    = 1'b0;
    ev_long   = 1'b0;
    if (down) begin
      if (cnt < ft_ext) begin
        cnt_d = ft_ext;
      end else if (cnt < band) begin
        cnt_d = cnt + KDEF_CNT_W'(1);
      end else begin
        if (!pressed) begin
          pressed_d = 1'b1;
          ev_press  = 1'b1;
        end
        if (cfg_i.long_time != '0) begin
          if (hold < cfg_i.long_time) begin
            hold_d  = hold_inc;
            ev_long = (hold_inc >= cfg_i.long_time);
          end else if (cfg_i.repeat_period != '0) begin
            if (rep_inc >= cfg_i.repeat_period) begin
              rep_d  = '0;
              ev_rep = 1'b1;
            end else begin
              rep_d = rep_inc;
            end
          end
        end
      end
    end else begin
      if (cnt > ft_ext) begin
        cnt_d = ft_ext;
      end else if (cnt != '0) begin
        cnt_d = cnt - KDEF_CNT_W'(1);
      end else if (pressed) begin
        pressed_d = 1'b0;
        ev_rel    = 1'b1;
      end
      hold_d = '0;
      rep_d  = '0;
    end
  end

  // first event of the step; a long press that lands with a press goes second
  always_comb begin
    if (ev_rel) begin
      code_a = kdef_code(k_ext, KIND_RELEASE);
    end else if (ev_press || ev_rep) begin
      code_a = kdef_code(k_ext, KIND_PRESS);
    end else begin
      code_a = kdef_code(k_ext, KIND_LONG);
    end
  end

  assign a_valid     = ev_press | ev_rel | ev_rep | ev_long;
  assign long_pend_o = ev_press & ev_long;
  assign ev_valid_o  = (cmd_i.key_step & a_valid) | cmd_i.push_long;
  assign ev_code_o   = cmd_i.push_long ? kdef_code(k_ext, KIND_LONG) : code_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        cnt_q[i]     <= KDEF_COUNT_RESET;
        pressed_q[i] <= 1'b0;
        hold_q[i]    <= '0;
        rep_q[i]     <= '0;
      end
    end else if (cmd_i.key_step) begin
      cnt_q[key_idx_i]     <= cnt_d;
      pressed_q[key_idx_i] <= pressed_d;
      hold_q[key_idx_i]    <= hold_d;
      rep_q[key_idx_i]     <= rep_d;
    end
  end

endmodule

>>> hdl/kdef_queue.sv
// Event FIFO: one push or one pop per cycle, drops on full with sticky flag.
`timescale 1ns / 1ps
`include "key_debounce_event_fifo_assert.svh"
module kdef_queue import kdef_pkg::*; #(
  parameter int QUEUE_DEPTH = KDEF_QUEUE_DEPTH,
  localparam int PTR_W      = $clog2(QUEUE_DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kdef_cmd_t              cmd_i,
  input  logic                   push_valid_i,
  input  logic [KDEF_CODE_W-1:0] push_code_i,
  output kdef_out_t              res_o
);

  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [KDEF_CODE_W-1:0] mem [QUEUE_DEPTH];
  logic [KDEF_CODE_W-1:0] rdata_q;
  logic [PTR_W-1:0]       wr_q, rd_q, wr_next, rd_next;
  logic                   ovf_q, hit_q;
  logic                   full, empty;

  assign wr_next = (wr_q == LAST) ? '0 : wr_q + PTR_W'(1);
  assign rd_next = (rd_q == LAST) ? '0 : rd_q + PTR_W'(1);
  assign full    = (wr_next == rd_q);
  assign empty   = (rd_q == wr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      ovf_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      if (push_valid_i) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          wr_q <= wr_next;
        end
      end
      if (cmd_i.pop) begin
        hit_q <= !empty;
        if (!empty) begin
          rd_q <= rd_next;
        end
      end else if (cmd_i.start) begin
        hit_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        rd_q <= wr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i && !full) begin
      mem[wr_q] <= push_code_i;
    end
    if (cmd_i.pop) begin
      rdata_q <= mem[rd_q];
    end
  end

  assign res_o.key_code    = hit_q ? rdata_q : '0;
  assign res_o.queue_empty = empty;
  assign res_o.overflowed  = ovf_q;

  `KDEF_ASSERT_NXT(a_full_drop, clk_i, rst_ni, push_valid_i && full, ovf_q && wr_q == $past(wr_q))
  `KDEF_ASSERT_NXT(a_empty_pop, clk_i, rst_ni, cmd_i.pop && empty, !hit_q && rd_q == $past(rd_q))

endmodule

>>> hdl/kdef_ctrl.sv
// Sequencer: walks the keys on a scan, runs pop and clear, holds the result beat.
`timescale 1ns / 1ps
`include "key_debounce_event_fifo_assert.svh"
module kdef_ctrl import kdef_pkg::*; #(
  parameter int NUM_KEYS = KDEF_NUM_KEYS,
  localparam int KIDX_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        in_cmd_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kdef_out_t         out_data_o,
  input  kdef_out_t         res_i,
  input  logic              long_pend_i,
  output kdef_cmd_t         cmd_o,
  output logic [KIDX_W-1:0] key_idx_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LONG,
    ST_POP,
    ST_CLEAR,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [KIDX_W-1:0] key_idx_q;
  logic              out_valid_q;
  kdef_out_t         out_data_q;
  logic              accept, last_key, load_res;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign last_key = (key_idx_q == KIDX_W'(NUM_KEYS - 1));
  // result register is free, or empties at this edge
  assign load_res = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    cmd_o           = '0;
    cmd_o.start     = accept;
    cmd_o.key_step  = (state_q == ST_SCAN);
    cmd_o.push_long = (state_q == ST_LONG);
    cmd_o.pop       = (state_q == ST_POP);
    cmd_o.clear     = (state_q == ST_CLEAR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_idx_q   <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      out_valid_q <= load_res || (out_valid_q && out_stall_i);
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            key_idx_q <= '0;
            unique case (kdef_cmd_e'(in_cmd_i))
              CMD_SCAN:  state_q <= ST_SCAN;
              CMD_POP:   state_q <= ST_POP;
              CMD_CLEAR: state_q <= ST_CLEAR;
              default:   state_q <= ST_DONE;
            endcase
          end
        end
        ST_SCAN: begin
          if (long_pend_i) begin
            state_q <= ST_LONG;
          end else if (last_key) begin
            state_q <= ST_DONE;
          end else begin
            key_idx_q <= key_idx_q + KIDX_W'(1);
          end
        end
        ST_LONG: begin
          if (last_key) begin
            state_q <= ST_DONE;
          end else begin
            key_idx_q <= key_idx_q + KIDX_W'(1);
            state_q   <= ST_SCAN;
          end
        end
        ST_POP, ST_CLEAR: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (load_res) begin
            out_data_q <= res_i;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign key_idx_o   = key_idx_q;

  `KDEF_ASSERT_NXT(a_scan_start, clk_i, rst_ni, accept && in_cmd_i == CMD_SCAN, state_q == ST_SCAN && key_idx_q == '0)
  `KDEF_ASSERT_NXT(a_long_next, clk_i, rst_ni, state_q == ST_SCAN && long_pend_i, state_q == ST_LONG)
  `KDEF_ASSERT_NXT(a_result_load, clk_i, rst_ni, state_q == ST_DONE && !out_valid_q, out_valid_q && state_q == ST_IDLE)

endmodule

>>> hdl/key_debounce_event_fifo.sv
// Top level of the key debounce event FIFO: config registers and block wiring.
`timescale 1ns / 1ps
// Debounces NUM_KEYS key levels on each scan beat (command 0) with a hysteresis
// counter per key and queues event codes 3k+1 press, 3k+2 release, 3k+3 long
// press (plus repeated 3k+1 after a long press when repeat_period is nonzero).
// Command 1 pops the oldest code (0 when empty), command 2 empties the queue,
// command 3 only reports status. Every input beat yields exactly one result
// beat carrying the popped code, the empty flag and the sticky overflow flag;
// an event that finds the queue full (QUEUE_DEPTH-1 entries) is dropped.
// Timing: one beat at a time. During a scan the per-key sequencer visits one
// key a cycle, with an extra step for each key whose press and long-press
// events fall on the same tick, and the event store has a single write port.
// The result sits in an output register, so the next beat is accepted while
// it waits. Config writes are always ready and must only happen while the
// block is idle.
module key_debounce_event_fifo import kdef_pkg::*; #(
  parameter int NUM_KEYS    = KDEF_NUM_KEYS,
  parameter int QUEUE_DEPTH = KDEF_QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  kdef_in_t                   in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output kdef_out_t                  out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [KDEF_CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [KDEF_CFG_DATA_W-1:0] cfg_data_i
);

  localparam int KIDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  kdef_cfg_t              cfg_q;
  kdef_cmd_t              cmd;
  kdef_out_t              res;
  logic [KIDX_W-1:0]      key_idx;
  logic                   long_pend;
  logic                   ev_valid;
  logic [KDEF_CODE_W-1:0] ev_code;

  // Config register file; writes to unused indexes are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_time   <= KDEF_FILTER_RESET;
      cfg_q.long_time     <= KDEF_LONG_RESET;
      cfg_q.repeat_period <= KDEF_REPEAT_RESET;
    end else if (cfg_valid_i) begin
      unique case (kdef_reg_e'(cfg_index_i))
        REG_FILTER: cfg_q.filter_time   <= cfg_data_i[KDEF_FT_W-1:0];
        REG_LONG:   cfg_q.long_time     <= cfg_data_i[KDEF_TICK_W-1:0];
        REG_REPEAT: cfg_q.repeat_period <= cfg_data_i[KDEF_TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: owns the handshakes, the key index and the result register.
  kdef_ctrl #(
    .NUM_KEYS(NUM_KEYS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_cmd_i    (in_data_i.command),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .res_i       (res),
    .long_pend_i (long_pend),
    .cmd_o       (cmd),
    .key_idx_o   (key_idx)
  );

  // Key state: debounce count, pressed flag, hold and repeat timers per key.
  kdef_keys #(
    .NUM_KEYS(NUM_KEYS)
  ) u_keys (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .key_idx_i   (key_idx),
    .levels_i    (in_data_i.key_levels),
    .long_pend_o (long_pend),
    .ev_valid_o  (ev_valid),
    .ev_code_o   (ev_code)
  );

  // Event store with pointers, registered read and overflow flag.
  kdef_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .push_valid_i (ev_valid),
    .push_code_i  (ev_code),
    .res_o        (res)
  );

endmodule

>>> test/key_debounce_event_fifo_checker.sv
// Checker of the key debounce event FIFO: predicts every result beat and compares it.
`timescale 1ns / 1ps
module key_debounce_event_fifo_checker import kdef_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  kdef_in_t                   in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  kdef_out_t                  out_data_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [KDEF_CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [KDEF_CFG_DATA_W-1:0] cfg_data_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int PTR_W = $clog2(KDEF_QUEUE_DEPTH);

  kdef_cfg_t              cfg;
  logic [KDEF_CNT_W-1:0]  bounce_cnt   [KDEF_NUM_KEYS];
  logic                   key_held     [KDEF_NUM_KEYS];
  logic [KDEF_TICK_W-1:0] held_ticks   [KDEF_NUM_KEYS];
  logic [KDEF_TICK_W-1:0] repeat_ticks [KDEF_NUM_KEYS];
  logic [KDEF_CODE_W-1:0] event_ram    [KDEF_QUEUE_DEPTH];
  logic [PTR_W-1:0]       rd_ptr;
  logic [PTR_W-1:0]       wr_ptr;
  logic                   dropped;
  kdef_out_t              status_q [$];
  int                     fails = 0;

  function automatic logic [KDEF_CODE_W-1:0] event_code(input int k, input kdef_kind_e kind);
    return KDEF_CODE_W'(3 * k + int'(kind));
  endfunction

  // One slot stays free: a full queue drops the event and sets the sticky flag.
  task automatic queue_event(input logic [KDEF_CODE_W-1:0] code);
    if (PTR_W'(wr_ptr + 1'b1) == rd_ptr) begin
      dropped = 1'b1;
    end else begin
      event_ram[wr_ptr] = code;
      wr_ptr = wr_ptr + 1'b1;
    end
  endtask

  task automatic scan_key(input int k, input logic down);
    logic [KDEF_CNT_W-1:0] band;
    band = {cfg.filter_time, 1'b0};
    if (down) begin
      if (bounce_cnt[k] < KDEF_CNT_W'(cfg.filter_time)) begin
        bounce_cnt[k] = KDEF_CNT_W'(cfg.filter_time);
      end else if (bounce_cnt[k] < band) begin
        bounce_cnt[k] = bounce_cnt[k] + 1'b1;
      end else begin
        if (!key_held[k]) begin
          key_held[k] = 1'b1;
          queue_event(event_code(k, KIND_PRESS));
        end
        if (cfg.long_time != '0) begin
          if (held_ticks[k] < cfg.long_time) begin
            held_ticks[k] = held_ticks[k] + 1'b1;
            if (held_ticks[k] >= cfg.long_time) queue_event(event_code(k, KIND_LONG));
          end else if (cfg.repeat_period != '0) begin
            repeat_ticks[k] = repeat_ticks[k] + 1'b1;
            if (repeat_ticks[k] >= cfg.repeat_period) begin
              repeat_ticks[k] = '0;
              queue_event(event_code(k, KIND_PRESS));
            end
          end
        end
      end
    end else begin
      if (bounce_cnt[k] > KDEF_CNT_W'(cfg.filter_time)) begin
        bounce_cnt[k] = KDEF_CNT_W'(cfg.filter_time);
      end else if (bounce_cnt[k] != '0) begin
        bounce_cnt[k] = bounce_cnt[k] - 1'b1;
      end else if (key_held[k]) begin
        key_held[k] = 1'b0;
        queue_event(event_code(k, KIND_RELEASE));
      end
      held_ticks[k]   = '0;
      repeat_ticks[k] = '0;
    end
  endtask

  task automatic run_command(input kdef_in_t beat, output kdef_out_t res);
    res = '0;
    case (beat.command)
      CMD_SCAN: begin
        for (int k = 0; k < KDEF_NUM_KEYS; k++) scan_key(k, beat.key_levels[k]);
      end
      CMD_POP: begin
        if (rd_ptr != wr_ptr) begin
          res.key_code = event_ram[rd_ptr];
          rd_ptr = rd_ptr + 1'b1;
        end
      end
      CMD_CLEAR: begin
        rd_ptr = wr_ptr;
      end
      default: ;
    endcase
    res.queue_empty = (rd_ptr == wr_ptr);
    res.overflowed  = dropped;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    kdef_out_t predicted;
    kdef_out_t want;
    if (!rst_ni) begin
      cfg.filter_time   = KDEF_FILTER_RESET;
      cfg.long_time     = KDEF_LONG_RESET;
      cfg.repeat_period = KDEF_REPEAT_RESET;
      for (int k = 0; k < KDEF_NUM_KEYS; k++) begin
        bounce_cnt[k]   = KDEF_COUNT_RESET;
        key_held[k]     = 1'b0;
        held_ticks[k]   = '0;
        repeat_ticks[k] = '0;
      end
      rd_ptr  = '0;
      wr_ptr  = '0;
      dropped = 1'b0;
      status_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_FILTER: cfg.filter_time   = cfg_data_i[KDEF_FT_W-1:0];
          REG_LONG:   cfg.long_time     = cfg_data_i[KDEF_TICK_W-1:0];
          REG_REPEAT: cfg.repeat_period = cfg_data_i[KDEF_TICK_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        run_command(in_data_i, predicted);
        status_q.push_back(predicted);
      end
      if (out_valid_i && !out_stall_i) begin
        if (status_q.size() == 0) begin
          $error("result beat with no command waiting for it");
          fails++;
        end else begin
          want = status_q.pop_front();
          if (out_data_i.key_code !== want.key_code) begin
            $error("key_code: expected %0d, got %0d", want.key_code, out_data_i.key_code);
            fails++;
          end
          if (out_data_i.queue_empty !== want.queue_empty) begin
            $error("queue_empty: expected %0b, got %0b", want.queue_empty,
                   out_data_i.queue_empty);
            fails++;
          end
          if (out_data_i.overflowed !== want.overflowed) begin
            $error("overflowed: expected %0b, got %0b", want.overflowed,
                   out_data_i.overflowed);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= status_q.size();
  end

endmodule

>>> test/key_debounce_event_fifo_tb.sv
// Testbench top of the key debounce event FIFO: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module key_debounce_event_fifo_tb;
  import kdef_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int NUM_PHASES  = 7;
  localparam int PHASE_BEATS = 200;
  // Receiver hold-off, long enough that the input side backs up.
  localparam int HOLD_CYCLES = 300;
  // Slowest beat: a scan visits every key, plus an extra step per key with a
  // press and long press on the same tick; even with a 53% receiver stall and
  // the hold-off above, no gap comes near this.
  localparam int QUIET_LIMIT = 3000;
  // Tail wait once every result is in.
  localparam int TAIL_CYCLES = 20;
  // Spare command code with no enum member; the block must ignore it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  kdef_in_t                   in_data;
  logic                       out_valid;
  logic                       out_stall;
  kdef_out_t                  out_data;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [KDEF_CFG_IDX_W-1:0]  cfg_index;
  logic [KDEF_CFG_DATA_W-1:0] cfg_data;

  int                     chk_fails;
  int                     chk_pending;
  int                     send_idle_pct = 23;
  int                     recv_idle_pct = 53;
  bit                     hold_req = 1'b0;
  int                     quiet_cycles = 0;
  // Debounced-looking key levels that the random scans mostly follow.
  logic [KDEF_LEVELS_W-1:0] held_levels = '0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  key_debounce_event_fifo i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  key_debounce_event_fifo_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (chk_fails),
    .pending_o    (chk_pending)
  );

  // Receiver: random stall per cycle, or one long hold-off when asked for.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: too many cycles without any beat on any channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("key_debounce_event_fifo verification failed");
        $finish;
      end
    end
  end

  // Offer one command beat after a random gap and hold it until taken.
  task automatic send_beat(input kdef_in_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic issue(input logic [1:0] cmd, input logic [KDEF_LEVELS_W-1:0] levels,
                       input int count);
    kdef_in_t beat;
    beat.command    = cmd;
    beat.key_levels = levels;
    repeat (count) send_beat(beat);
  endtask

  // Stop offering and wait for every outstanding result; leaves the block idle.
  // Always advances the clock before checking, so in_valid sees one update per step.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk_pending != 0);
  endtask

  task automatic write_reg(input kdef_reg_e idx, input logic [KDEF_CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Filter time sits in the low bits; the upper bits get junk the block must drop.
  task automatic write_config(input logic [KDEF_FT_W-1:0] ft,
                              input logic [KDEF_TICK_W-1:0] lt,
                              input logic [KDEF_TICK_W-1:0] rp);
    write_reg(REG_FILTER, {(KDEF_CFG_DATA_W - KDEF_FT_W)'($urandom), ft});
    write_reg(REG_LONG, lt);
    write_reg(REG_REPEAT, rp);
    cfg_valid <= 1'b0;
  endtask

  // Random beats: mostly scans that follow slowly changing key levels (so
  // presses, long presses and repeats actually qualify), plus pops, clears,
  // the spare command and the odd noise scan with random levels.
  task automatic run_phase(input int beats, input int flip_span, input int pop_pct,
                           input bit with_hold);
    kdef_in_t beat;
    int       roll;
    for (int i = 0; i < beats; i++) begin
      roll            = $urandom_range(99);
      beat.key_levels = KDEF_LEVELS_W'($urandom);
      if (roll < pop_pct) begin
        beat.command = CMD_POP;
      end else if (roll < pop_pct + 4) begin
        beat.command = CMD_CLEAR;
      end else if (roll < pop_pct + 7) begin
        beat.command = CMD_UNUSED;
      end else begin
        beat.command = CMD_SCAN;
        if ($urandom_range(9) != 0) begin
          for (int k = 0; k < KDEF_NUM_KEYS; k++) begin
            if ($urandom_range(flip_span - 1) == 0) held_levels[k] = ~held_levels[k];
          end
          beat.key_levels = held_levels;
        end
      end
      // Receiver stops taking results while we keep pushing commands.
      if (with_hold && i == beats / 4) hold_req = 1'b1;
      send_beat(beat);
    end
  endtask

  initial begin
    logic [KDEF_FT_W-1:0]   ft;
    logic [KDEF_TICK_W-1:0] lt;
    logic [KDEF_TICK_W-1:0] rp;
    int                     span;
    int                     pop_pct;
    rst_n     = 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, at reset settings: empty pop, spare command, empty clear.
    issue(CMD_POP, 4'hF, 1);
    issue(CMD_UNUSED, 4'hF, 1);
    issue(CMD_CLEAR, 4'h0, 1);
    // All keys down through the default filter band: four presses on tick 7.
    issue(CMD_SCAN, 4'hF, 7);
    issue(CMD_POP, 4'h0, 1);
    // Shrink the filter: counts above the new bound drop to it at once.
    drain_results();
    write_config(KDEF_FT_W'(1), KDEF_TICK_W'(1), KDEF_TICK_W'(1));
    issue(CMD_SCAN, 4'h0, 3);
    // Press and long press on the same tick fill the queue; the repeat
    // press on the next tick finds it full and sets the sticky flag.
    issue(CMD_SCAN, 4'hF, 4);
    issue(CMD_POP, 4'h5, 1);
    issue(CMD_CLEAR, 4'hA, 1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin ft = 6'd2;  lt = 16'd6;     rp = 16'd3;     span = 14;  pop_pct = 35; end
        1: begin ft = 6'd63; lt = 16'd0;     rp = 16'd0;     span = 300; pop_pct = 30; end
        2: begin ft = 6'd0;  lt = 16'd1;     rp = 16'd1;     span = 4;   pop_pct = 40; end
        3: begin ft = 6'd1;  lt = 16'hFFFF;  rp = 16'hFFFF;  span = 6;   pop_pct = 35; end
        4: begin ft = 6'd7;  lt = 16'd20;    rp = 16'd0;     span = 40;  pop_pct = 35; end
        5: begin ft = 6'd3;  lt = 16'd4;     rp = 16'd2;     span = 16;  pop_pct = 30; end
        default: begin
          ft = 6'd5; lt = 16'd12; rp = 16'd1; span = 30; pop_pct = 40;
        end
      endcase
      // Idle mix: sender light / receiver heavy, then swapped, then none.
      if (p == 3) begin
        send_idle_pct = 53;
        recv_idle_pct = 23;
      end else if (p == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Sender pauses until every result is back, then the settings change.
      drain_results();
      write_config(ft, lt, rp);
      run_phase(PHASE_BEATS, span, pop_pct, p == 1);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("key_debounce_event_fifo verification clean");
    end else begin
      $display("key_debounce_event_fifo verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/kdef_pkg.sv
hdl/kdef_keys.sv
hdl/kdef_queue.sv
hdl/kdef_ctrl.sv
hdl/key_debounce_event_fifo.sv
test/key_debounce_event_fifo_checker.sv
test/key_debounce_event_fifo_tb.sv
